>>> rtl/core/rfb_server_message_parser_unit_defines.svh
// Assertion macros for the RFB server message parser unit.
// Used by the top level; the macros expect signals named clock and reset in scope.
`ifndef RFB_SERVER_MESSAGE_PARSER_UNIT_DEFINES_SVH
`define RFB_SERVER_MESSAGE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RFBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define RFBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/rfbp_pkg.sv
// Package for the RFB server message parser: parse phases, message and
// register codes, and the result type. No dependencies.
`timescale 1ns / 1ps

package rfbp_pkg;

   // parse phase of the byte stream
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_FBU_PAD  = 4'd1,
      PH_FBU_CNT  = 4'd2,
      PH_RECT_HDR = 4'd3,
      PH_PIXELS   = 4'd4,
      PH_CUT_HDR  = 4'd5,
      PH_CUT_TEXT = 4'd6,
      PH_HALT     = 4'd7
   } phase_type;

   // server message types
   localparam logic [7:0] MSG_FB_UPDATE = 8'd0;
   localparam logic [7:0] MSG_BELL      = 8'd2;
   localparam logic [7:0] MSG_CUT_TEXT  = 8'd3;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN_MSG = 2'd2;

   // configuration register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // cut text of this length or longer is not skipped
   localparam logic [31:0] CUT_TEXT_LIMIT = 32'd65536;

   // one result of the parser, valid marks that it carries an event
   typedef struct packed {
      logic        valid;
      logic        pixel_valid;
      logic [31:0] pixel_address;
      logic [31:0] pixel_value;
      logic        rect_done;
      logic        update_done;
      logic [1:0]  error_code;
   } result_type;

endpackage

>>> rtl/core/rfbp_if.sv
// Channel interfaces of the RFB server message parser: request byte,
// result and configuration write. No dependencies.
`timescale 1ns / 1ps

interface rfbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface rfbp_rsp_if;
   logic        valid;
   logic        ready;
   logic        pixel_valid;
   logic [31:0] pixel_address;
   logic [31:0] pixel_value;
   logic        rect_done;
   logic        update_done;
   logic [1:0]  error_code;

   modport source (output valid, output pixel_valid, output pixel_address,
                   output pixel_value, output rect_done, output update_done,
                   output error_code, input ready);
   modport sink (input valid, input pixel_valid, input pixel_address,
                 input pixel_value, input rect_done, input update_done,
                 input error_code, output ready);
endinterface

interface rfbp_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/core/rfbp_parser.sv
// Parse state machine of the RFB server message parser: takes one byte per
// fire, updates the message state and forms the result. Uses rfbp_pkg.
`timescale 1ns / 1ps

module rfbp_parser import rfbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [7:0]  byte_in,
   input  logic [15:0] frame_width,
   input  logic [15:0] frame_height,
   output result_type  result,
   output phase_type   phase
);

   // byte positions inside the headers
   localparam logic [3:0] HDR_X_HI   = 4'd0;
   localparam logic [3:0] HDR_X_LO   = 4'd1;
   localparam logic [3:0] HDR_Y_HI   = 4'd2;
   localparam logic [3:0] HDR_Y_LO   = 4'd3;
   localparam logic [3:0] HDR_W_HI   = 4'd4;
   localparam logic [3:0] HDR_W_LO   = 4'd5;
   localparam logic [3:0] HDR_H_HI   = 4'd6;
   localparam logic [3:0] HDR_H_LO   = 4'd7;
   localparam logic [3:0] HDR_LAST   = 4'd11;
   localparam logic [3:0] CUT_LEN_0  = 4'd3;
   localparam logic [3:0] CUT_LAST   = 4'd6;
   localparam logic [1:0] PIX_LAST   = 2'd3;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [15:0] rects_ff, rects_in;
   logic [15:0] rect_x_ff, rect_x_in;
   logic [15:0] rect_y_ff, rect_y_in;
   logic [15:0] rect_w_ff, rect_w_in;
   logic [15:0] rect_h_ff, rect_h_in;
   logic [23:0] enc_ff, enc_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [23:0] partial_ff, partial_in;
   logic [1:0]  pbi_ff, pbi_in;
   logic [23:0] text_ff, text_in;

   logic        frame_nz;
   logic [15:0] cnt_full;
   logic [15:0] rects_dec;
   logic        last_rect;
   logic [31:0] enc_full;
   logic        enc_bad;
   logic        hdr_last;
   logic        rect_empty;
   logic        pix_last;
   logic [16:0] dy;
   logic [16:0] dx;
   logic        hit;
   logic [31:0] prod;
   logic [31:0] addr;
   logic [16:0] col_next;
   logic [16:0] row_next;
   logic        col_wrap;
   logic        row_wrap;
   logic        rect_end;
   logic [31:0] text_full;
   logic        cut_ok;
   logic [23:0] text_dec;

   // decode the current byte against the state
   always_comb begin
      frame_nz   = (frame_width != 16'd0) && (frame_height != 16'd0);
      cnt_full   = {rects_ff[15:8], byte_in};
      rects_dec  = rects_ff - 16'd1;
      last_rect  = (rects_dec == 16'd0);
      enc_full   = {enc_ff, byte_in};
      enc_bad    = (enc_full != 32'd0);
      hdr_last   = (hdr_idx_ff == HDR_LAST);
      rect_empty = (rect_w_ff == 16'd0) || (rect_h_ff == 16'd0);
      pix_last   = (pbi_ff == PIX_LAST);
      dy         = {1'b0, rect_y_ff} + {1'b0, row_ff};
      dx         = {1'b0, rect_x_ff} + {1'b0, col_ff};
      hit        = frame_nz && (dy < {1'b0, frame_height}) && (dx < {1'b0, frame_width});
      prod       = dy[15:0] * frame_width;
      addr       = prod + {15'd0, dx};
      col_next   = {1'b0, col_ff} + 17'd1;
      row_next   = {1'b0, row_ff} + 17'd1;
      col_wrap   = (col_next >= {1'b0, rect_w_ff});
      row_wrap   = (row_next >= {1'b0, rect_h_ff});
      rect_end   = ((phase_ff == PH_RECT_HDR) && hdr_last && !enc_bad && rect_empty) ||
                   ((phase_ff == PH_PIXELS) && pix_last && col_wrap && row_wrap);
      text_full  = {text_ff, byte_in};
      cut_ok     = (text_full != 32'd0) && (text_full < CUT_TEXT_LIMIT);
      text_dec   = text_ff - 24'd1;
   end

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (byte_in == MSG_FB_UPDATE) begin
               phase_in = PH_FBU_PAD;
            end else if (byte_in == MSG_CUT_TEXT) begin
               phase_in = PH_CUT_HDR;
            end else if (byte_in != MSG_BELL) begin
               phase_in = PH_HALT;
            end
         end
         PH_FBU_PAD: begin
            phase_in = PH_FBU_CNT;
         end
         PH_FBU_CNT: begin
            if (hdr_idx_ff != 4'd0) begin
               phase_in = (cnt_full == 16'd0) ? PH_IDLE : PH_RECT_HDR;
            end
         end
         PH_RECT_HDR: begin
            if (hdr_last) begin
               if (enc_bad) begin
                  phase_in = PH_HALT;
               end else if (rect_empty) begin
                  phase_in = last_rect ? PH_IDLE : PH_RECT_HDR;
               end else begin
                  phase_in = PH_PIXELS;
               end
            end
         end
         PH_PIXELS: begin
            if (rect_end) begin
               phase_in = last_rect ? PH_IDLE : PH_RECT_HDR;
            end
         end
         PH_CUT_HDR: begin
            if (hdr_idx_ff == CUT_LAST) begin
               phase_in = cut_ok ? PH_CUT_TEXT : PH_IDLE;
            end
         end
         PH_CUT_TEXT: begin
            if (text_dec == 24'd0) begin
               phase_in = PH_IDLE;
            end
         end
         PH_HALT: begin
            phase_in = PH_HALT;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // header fields, counters and pixel assembly
   always_comb begin
      hdr_idx_in = hdr_idx_ff;
      rects_in   = rects_ff;
      rect_x_in  = rect_x_ff;
      rect_y_in  = rect_y_ff;
      rect_w_in  = rect_w_ff;
      rect_h_in  = rect_h_ff;
      enc_in     = enc_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      partial_in = partial_ff;
      pbi_in     = pbi_ff;
      text_in    = text_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (byte_in == MSG_CUT_TEXT) begin
               hdr_idx_in = 4'd0;
               text_in    = 24'd0;
            end
         end
         PH_FBU_PAD: begin
            hdr_idx_in = 4'd0;
         end
         PH_FBU_CNT: begin
            if (hdr_idx_ff == 4'd0) begin
               rects_in   = {byte_in, 8'h00};
               hdr_idx_in = 4'd1;
            end else begin
               rects_in   = cnt_full;
               hdr_idx_in = 4'd0;
            end
         end
         PH_RECT_HDR: begin
            case (hdr_idx_ff)
               HDR_X_HI: rect_x_in = {byte_in, 8'h00};
               HDR_X_LO: rect_x_in = {rect_x_ff[15:8], byte_in};
               HDR_Y_HI: rect_y_in = {byte_in, 8'h00};
               HDR_Y_LO: rect_y_in = {rect_y_ff[15:8], byte_in};
               HDR_W_HI: rect_w_in = {byte_in, 8'h00};
               HDR_W_LO: rect_w_in = {rect_w_ff[15:8], byte_in};
               HDR_H_HI: rect_h_in = {byte_in, 8'h00};
               HDR_H_LO: rect_h_in = {rect_h_ff[15:8], byte_in};
               default:  enc_in    = enc_full[23:0];
            endcase
            if (!hdr_last) begin
               hdr_idx_in = hdr_idx_ff + 4'd1;
            end else begin
               hdr_idx_in = 4'd0;
               if (!enc_bad) begin
                  row_in     = 16'd0;
                  col_in     = 16'd0;
                  partial_in = 24'd0;
                  pbi_in     = 2'd0;
                  if (rect_empty) begin
                     rects_in = rects_dec;
                  end
               end
            end
         end
         PH_PIXELS: begin
            if (!pix_last) begin
               partial_in[8*pbi_ff +: 8] = byte_in;
               pbi_in = pbi_ff + 2'd1;
            end else begin
               partial_in = 24'd0;
               pbi_in     = 2'd0;
               col_in     = col_next[15:0];
               if (col_wrap) begin
                  col_in = 16'd0;
                  row_in = row_next[15:0];
                  if (row_wrap) begin
                     rects_in   = rects_dec;
                     hdr_idx_in = 4'd0;
                  end
               end
            end
         end
         PH_CUT_HDR: begin
            if (hdr_idx_ff >= CUT_LEN_0) begin
               text_in = text_full[23:0];
            end
            if (hdr_idx_ff != CUT_LAST) begin
               hdr_idx_in = hdr_idx_ff + 4'd1;
            end else begin
               hdr_idx_in = 4'd0;
               text_in    = cut_ok ? text_full[23:0] : 24'd0;
            end
         end
         PH_CUT_TEXT: begin
            text_in = text_dec;
         end
         default: begin
            hdr_idx_in = hdr_idx_ff;
         end
      endcase
   end

   // result of this byte
   always_comb begin
      result               = '0;
      result.pixel_valid   = (phase_ff == PH_PIXELS) && pix_last && hit;
      result.pixel_address = result.pixel_valid ? addr : 32'd0;
      result.pixel_value   = result.pixel_valid ? {byte_in, partial_ff} : 32'd0;
      result.rect_done     = rect_end && frame_nz;
      result.update_done   = ((phase_ff == PH_FBU_CNT) && (hdr_idx_ff != 4'd0) &&
                              (cnt_full == 16'd0)) || (rect_end && last_rect);
      result.error_code    = ERR_NONE;
      if ((phase_ff == PH_IDLE) && (byte_in != MSG_FB_UPDATE) &&
          (byte_in != MSG_BELL) && (byte_in != MSG_CUT_TEXT)) begin
         result.error_code = ERR_UNKNOWN_MSG;
      end else if ((phase_ff == PH_RECT_HDR) && hdr_last && enc_bad) begin
         result.error_code = ERR_UNSUPPORTED;
      end
      result.valid = result.pixel_valid || result.rect_done || result.update_done ||
                     (result.error_code != ERR_NONE);
   end

   // advance the state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hdr_idx_ff <= 4'd0;
         rects_ff   <= 16'd0;
         rect_x_ff  <= 16'd0;
         rect_y_ff  <= 16'd0;
         rect_w_ff  <= 16'd0;
         rect_h_ff  <= 16'd0;
         enc_ff     <= 24'd0;
         row_ff     <= 16'd0;
         col_ff     <= 16'd0;
         partial_ff <= 24'd0;
         pbi_ff     <= 2'd0;
         text_ff    <= 24'd0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         rects_ff   <= rects_in;
         rect_x_ff  <= rect_x_in;
         rect_y_ff  <= rect_y_in;
         rect_w_ff  <= rect_w_in;
         rect_h_ff  <= rect_h_in;
         enc_ff     <= enc_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         partial_ff <= partial_in;
         pbi_ff     <= pbi_in;
         text_ff    <= text_in;
      end
   end

   assign phase = phase_ff;

endmodule

>>> rtl/core/rfb_server_message_parser_unit.sv
// Top level of the RFB server message parser: input register, parser,
// result register and frame size registers. Uses rfbp_pkg, rfbp_if, rfbp_parser.
//
// Usage:
//   req_chan carries the server-to-client byte stream, one byte per request.
//   rsp_chan carries one result per byte that causes an event: a clipped
//   pixel write, rectangle done, update done or an error code. Bytes that
//   cause no event produce no result.
//   csr_chan writes frame_width (index 0) and frame_height (index 1); it is
//   always ready and should be written while no request is in flight.
// Timing:
//   A request is registered at acceptance and parsed from the input register once
//   the result register can take it; its result is then loaded into the result
//   register and is valid on rsp_chan. One request is accepted every cycle while
//   rsp_chan does not stall; the path through the parser (a 16x16 address multiply
//   and add) sets the clock.
// Reset: synchronous, clears the parse state, the frame size and the valid
//   flags of both registers. After an error the block halts and drops every
//   byte until reset.
// Stall: when rsp_chan is not ready, the held result blocks the parser and
//   req_chan.ready drops once the input register is also full.
`timescale 1ns / 1ps
`include "rfb_server_message_parser_unit_defines.svh"

module rfb_server_message_parser_unit import rfbp_pkg::*; (
   input logic          clock,
   input logic          reset,
   rfbp_req_if.sink     req_chan,
   rfbp_rsp_if.source   rsp_chan,
   rfbp_csr_if.sink     csr_chan
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff;
   result_type  rsp_data_ff;
   logic [15:0] frame_width_ff;
   logic [15:0] frame_height_ff;
   logic        advance;
   logic        fire;
   result_type  result;
   phase_type   phase;
   logic        rsp_has_event;
   logic        rsp_pixel_zero;
   logic        parse_error;

   // move when the result register is free or being drained
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   // hold the frame size
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 16'd0;
         frame_height_ff <= 16'd0;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_chan.wdata;
         end
         if (csr_chan.index == CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_chan.wdata;
         end
      end
   end

   // register the incoming request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.byte_in;
      end
   end

   rfbp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .byte_in      (in_byte_ff),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .result       (result),
      .phase        (phase)
   );

   // load the result register, drop bytes without events
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fire && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pixel_valid   = rsp_data_ff.pixel_valid;
   assign rsp_chan.pixel_address = rsp_data_ff.pixel_address;
   assign rsp_chan.pixel_value   = rsp_data_ff.pixel_value;
   assign rsp_chan.rect_done     = rsp_data_ff.rect_done;
   assign rsp_chan.update_done   = rsp_data_ff.update_done;
   assign rsp_chan.error_code    = rsp_data_ff.error_code;

   // terms for the checks
   assign rsp_has_event  = rsp_data_ff.pixel_valid || rsp_data_ff.rect_done ||
                           rsp_data_ff.update_done || (rsp_data_ff.error_code != ERR_NONE);
   assign rsp_pixel_zero = (rsp_data_ff.pixel_address == 32'd0) &&
                           (rsp_data_ff.pixel_value == 32'd0);
   assign parse_error    = fire && (result.error_code != ERR_NONE);

   // checks
   `RFBP_ASSERT_NOW(a_result_has_event, rsp_valid_ff, rsp_has_event, "result without event")
   `RFBP_ASSERT_NOW(a_unused_fields_zero, rsp_valid_ff && !rsp_data_ff.pixel_valid, rsp_pixel_zero, "pixel fields set")
   `RFBP_ASSERT_NEXT(a_error_halts, parse_error, phase == PH_HALT, "error did not halt")
   `RFBP_ASSERT_NEXT(a_halt_sticky, phase == PH_HALT, phase == PH_HALT, "parser left halt")

endmodule

>>> tb/sv/tb_rfb_server_message_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for rfb_server_message_parser_unit: feeds RFB server byte streams,
// predicts pixel writes, rectangle/update events and errors, and checks the result channel.
// Depends on rfbp_pkg, the rfbp_if channel interfaces and the parser RTL.

module tb_rfb_server_message_parser_unit;
   import rfbp_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_BYTES = 1800;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_type;

   logic clock;
   logic reset;

   rfbp_req_if req_bus ();
   rfbp_rsp_if rsp_bus ();
   rfbp_csr_if csr_bus ();

   rfb_server_message_parser_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // frame size as the block sees it
   logic [15:0] cfg_width  = '0;
   logic [15:0] cfg_height = '0;

   // parser state mirror
   phase_type   parse_ph     = PH_IDLE;
   logic [3:0]  hdr_pos      = '0;
   logic [15:0] rects_to_go  = '0;
   logic [15:0] rect_col0    = '0;
   logic [15:0] rect_row0    = '0;
   logic [15:0] rect_cols    = '0;
   logic [15:0] rect_rows    = '0;
   logic [31:0] rect_enc     = '0;
   logic [15:0] cur_row      = '0;
   logic [15:0] cur_col      = '0;
   logic [23:0] pixel_low    = '0;
   logic [1:0]  pixel_pos    = '0;
   logic [31:0] text_to_skip = '0;

   result_type  predicted_events[$];
   logic [7:0]  stream_bytes[$];
   logic [7:0]  byte_feed[$];

   int          bytes_queued   = 0;
   int          bytes_accepted = 0;
   int          mismatch_count = 0;
   int          send_gap_pct   = 0;
   int          recv_stall_pct = 0;
   int unsigned cycle_count    = 0;

   function automatic logic frame_is_set();
      return cfg_width != 16'd0 && cfg_height != 16'd0;
   endfunction

   // close the current rectangle, return {rect_done, update_done}
   function automatic logic [1:0] close_rect();
      logic last_rect;
      rects_to_go = rects_to_go - 16'd1;
      hdr_pos = '0;
      last_rect = (rects_to_go == 16'd0);
      parse_ph = last_rect ? PH_IDLE : PH_RECT_HDR;
      return {frame_is_set(), last_rect};
   endfunction

   // advance the parser mirror by one stream byte and record any event it causes
   task automatic decode_server_byte(input logic [7:0] b);
      result_type  ev;
      logic [31:0] dy;
      logic [31:0] dx;
      ev = '0;
      case (parse_ph)
         PH_IDLE: begin
            if (b == MSG_FB_UPDATE) begin
               parse_ph = PH_FBU_PAD;
            end else if (b == MSG_CUT_TEXT) begin
               parse_ph = PH_CUT_HDR;
               hdr_pos = '0;
               text_to_skip = '0;
            end else if (b != MSG_BELL) begin
               ev.error_code = ERR_UNKNOWN_MSG;
               parse_ph = PH_HALT;
            end
         end
         PH_FBU_PAD: begin
            parse_ph = PH_FBU_CNT;
            hdr_pos = '0;
         end
         PH_FBU_CNT: begin
            if (hdr_pos == 4'd0) begin
               rects_to_go = {b, 8'h00};
               hdr_pos = 4'd1;
            end else begin
               rects_to_go[7:0] = b;
               hdr_pos = '0;
               if (rects_to_go == 16'd0) begin
                  ev.update_done = 1'b1;
                  parse_ph = PH_IDLE;
               end else begin
                  parse_ph = PH_RECT_HDR;
               end
            end
         end
         PH_RECT_HDR: begin
            // big-endian x, y, w, h, then a 32-bit encoding
            case (hdr_pos)
               4'd0: rect_col0 = {b, 8'h00};
               4'd1: rect_col0[7:0] = b;
               4'd2: rect_row0 = {b, 8'h00};
               4'd3: rect_row0[7:0] = b;
               4'd4: rect_cols = {b, 8'h00};
               4'd5: rect_cols[7:0] = b;
               4'd6: rect_rows = {b, 8'h00};
               4'd7: rect_rows[7:0] = b;
               default: rect_enc = {rect_enc[23:0], b};
            endcase
            if (hdr_pos < 4'd11) begin
               hdr_pos = hdr_pos + 4'd1;
            end else begin
               hdr_pos = '0;
               if (rect_enc != 32'd0) begin
                  ev.error_code = ERR_UNSUPPORTED;
                  parse_ph = PH_HALT;
               end else begin
                  cur_row = '0;
                  cur_col = '0;
                  pixel_low = '0;
                  pixel_pos = '0;
                  if (rect_cols == 16'd0 || rect_rows == 16'd0) begin
                     {ev.rect_done, ev.update_done} = close_rect();
                  end else begin
                     parse_ph = PH_PIXELS;
                  end
               end
            end
         end
         PH_PIXELS: begin
            if (pixel_pos < 2'd3) begin
               pixel_low[8*pixel_pos +: 8] = b;
               pixel_pos = pixel_pos + 2'd1;
            end else begin
               // the column sum may carry past 16 bits, which clips it
               dy = 32'(rect_row0) + 32'(cur_row);
               dx = 32'(rect_col0) + 32'(cur_col);
               if (frame_is_set() && dy < 32'(cfg_height) && dx < 32'(cfg_width)) begin
                  ev.pixel_valid = 1'b1;
                  ev.pixel_address = dy * 32'(cfg_width) + dx;
                  ev.pixel_value = {b, pixel_low};
               end
               pixel_low = '0;
               pixel_pos = '0;
               cur_col = cur_col + 16'd1;
               if (cur_col >= rect_cols) begin
                  cur_col = '0;
                  cur_row = cur_row + 16'd1;
                  if (cur_row >= rect_rows) begin
                     {ev.rect_done, ev.update_done} = close_rect();
                  end
               end
            end
         end
         PH_CUT_HDR: begin
            if (hdr_pos >= 4'd3) begin
               text_to_skip = {text_to_skip[23:0], b};
            end
            if (hdr_pos < 4'd6) begin
               hdr_pos = hdr_pos + 4'd1;
            end else begin
               hdr_pos = '0;
               if (text_to_skip > 32'd0 && text_to_skip < CUT_TEXT_LIMIT) begin
                  parse_ph = PH_CUT_TEXT;
               end else begin
                  text_to_skip = '0;
                  parse_ph = PH_IDLE;
               end
            end
         end
         PH_CUT_TEXT: begin
            if (text_to_skip > 32'd0) begin
               text_to_skip = text_to_skip - 32'd1;
            end
            if (text_to_skip == 32'd0) begin
               parse_ph = PH_IDLE;
            end
         end
         PH_HALT: begin
            // drop everything until reset
         end
         default: begin
            parse_ph = PH_IDLE;
         end
      endcase
      if (ev.pixel_valid || ev.rect_done || ev.update_done || ev.error_code != ERR_NONE) begin
         ev.valid = 1'b1;
         predicted_events.push_back(ev);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // request driver: predict on acceptance, hold while stalled, then load the next byte
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_server_byte(req_bus.byte_in);
            bytes_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.byte_in <= byte_feed.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_events.size() == 0) begin
               $error("unexpected result: pixel_valid %0b address %0h value %0h rect %0b upd %0b err %0d",
                      rsp_bus.pixel_valid, rsp_bus.pixel_address, rsp_bus.pixel_value,
                      rsp_bus.rect_done, rsp_bus.update_done, rsp_bus.error_code);
               mismatch_count++;
            end else begin
               want = predicted_events.pop_front();
               compare_field("pixel_valid", 32'(want.pixel_valid), 32'(rsp_bus.pixel_valid));
               compare_field("pixel_address", want.pixel_address, rsp_bus.pixel_address);
               compare_field("pixel_value", want.pixel_value, rsp_bus.pixel_value);
               compare_field("rect_done", 32'(want.rect_done), 32'(rsp_bus.rect_done));
               compare_field("update_done", 32'(want.update_done), 32'(rsp_bus.update_done));
               compare_field("error_code", 32'(want.error_code), 32'(rsp_bus.error_code));
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic set_gap_mode(input gap_mode_type mode);
      case (mode)
         GAP_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         GAP_SENDER:   begin send_gap_pct = 57; recv_stall_pct = 0;  end
         GAP_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 57; end
         default:      begin send_gap_pct = 25; recv_stall_pct = 25; end
      endcase
   endtask

   task automatic write_register(input logic idx, input logic [15:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) cfg_width = value;
      else cfg_height = value;
   endtask

   task automatic write_frame_size(input logic [15:0] w, input logic [15:0] h);
      write_register(CSR_FRAME_WIDTH, w);
      write_register(CSR_FRAME_HEIGHT, h);
   endtask

   // hand n stream bytes to the driver, then hold off until every result is back
   task automatic feed_and_drain(input int n);
      repeat (n) begin
         byte_feed.push_back(stream_bytes.pop_front());
         bytes_queued++;
      end
      do @(posedge clock);
      while (bytes_accepted != bytes_queued || predicted_events.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_update_head(input logic [15:0] count);
      stream_bytes.push_back(MSG_FB_UPDATE);
      stream_bytes.push_back(8'($urandom()));
      stream_bytes.push_back(count[15:8]);
      stream_bytes.push_back(count[7:0]);
   endtask

   task automatic add_rect_head(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] w, input logic [15:0] h,
                                input logic [31:0] enc);
      stream_bytes.push_back(x[15:8]);
      stream_bytes.push_back(x[7:0]);
      stream_bytes.push_back(y[15:8]);
      stream_bytes.push_back(y[7:0]);
      stream_bytes.push_back(w[15:8]);
      stream_bytes.push_back(w[7:0]);
      stream_bytes.push_back(h[15:8]);
      stream_bytes.push_back(h[7:0]);
      for (int i = 3; i >= 0; i--) stream_bytes.push_back(enc[8*i +: 8]);
   endtask

   // pixel bytes go out least significant first
   task automatic add_pixel(input logic [31:0] word);
      for (int i = 0; i < 4; i++) stream_bytes.push_back(word[8*i +: 8]);
   endtask

   task automatic add_cut_text(input logic [31:0] len);
      stream_bytes.push_back(MSG_CUT_TEXT);
      repeat (3) stream_bytes.push_back(8'($urandom()));
      for (int i = 3; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
      if (len > 32'd0 && len < CUT_TEXT_LIMIT) begin
         repeat (len) stream_bytes.push_back(8'($urandom()));
      end
   endtask

   task automatic add_random_message();
      int          roll;
      int          count;
      logic [15:0] x, y, w, h;
      logic [31:0] len;
      roll = $urandom_range(0, 99);
      if (roll < 58) begin
         count = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 3);
         add_update_head(16'(count));
         repeat (count) begin
            x = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 14))
                                             : 16'($urandom_range(65528, 65535));
            y = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 11))
                                             : 16'($urandom_range(65528, 65535));
            w = ($urandom_range(0, 99) < 6) ? 16'd0 : 16'($urandom_range(1, 5));
            h = ($urandom_range(0, 99) < 6) ? 16'd0 : 16'($urandom_range(1, 4));
            add_rect_head(x, y, w, h, 32'd0);
            repeat (int'(w) * int'(h)) add_pixel($urandom());
         end
      end else if (roll < 78) begin
         stream_bytes.push_back(MSG_BELL);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 75) len = $urandom_range(1, 24);
         else if (roll < 85) len = $urandom_range(200, 300);
         else if (roll < 90) len = 32'd0;
         else if (roll < 95) len = CUT_TEXT_LIMIT + $urandom_range(0, 1000);
         else len = $urandom() | 32'h8000_0000;
         add_cut_text(len);
      end
   endtask

   // stimulus
   initial begin
      logic [31:0] enc;
      int          phase_no;
      int          roll;
      int          chunk;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.byte_in = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_FRAME_WIDTH;
      csr_bus.wdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_gap_mode(GAP_NONE);

      // frame size still zero after reset: pixels are eaten without writes
      stream_bytes.push_back(MSG_BELL);
      add_update_head(16'd0);
      add_update_head(16'd1);
      add_rect_head(16'd0, 16'd0, 16'd2, 16'd1, 32'd0);
      add_pixel($urandom());
      add_pixel($urandom());
      add_cut_text(32'd0);
      add_cut_text(CUT_TEXT_LIMIT);
      add_cut_text(32'hFFFF_FFFF);
      add_cut_text(32'd3);
      feed_and_drain(stream_bytes.size());

      // largest frame: clip past the right and bottom edges, empty last rectangle
      write_frame_size(16'hFFFF, 16'hFFFF);
      add_update_head(16'd2);
      add_rect_head(16'd65534, 16'd65533, 16'd3, 16'd3, 32'd0);
      repeat (9) add_pixel($urandom());
      add_rect_head(16'd5, 16'd0, 16'd0, 16'd4, 32'd0);
      // pixel write, rect done and update done all on the last byte
      add_update_head(16'd1);
      add_rect_head(16'd0, 16'd0, 16'd2, 16'd2, 32'd0);
      add_pixel(32'h0000_0000);
      add_pixel(32'hFFFF_FFFF);
      add_pixel($urandom());
      add_pixel($urandom());
      feed_and_drain(stream_bytes.size());

      // one dimension zero at a time
      write_register(CSR_FRAME_WIDTH, 16'd0);
      add_update_head(16'd1);
      add_rect_head(16'd0, 16'd0, 16'd1, 16'd1, 32'd0);
      add_pixel($urandom());
      feed_and_drain(stream_bytes.size());
      write_frame_size(16'd7, 16'd0);
      add_update_head(16'd1);
      add_rect_head(16'd1, 16'd1, 16'd1, 16'd1, 32'd0);
      add_pixel($urandom());
      feed_and_drain(stream_bytes.size());

      // random well-formed traffic, ended by an error that halts the block
      while (stream_bytes.size() < RANDOM_BYTES) add_random_message();
      if ($urandom_range(0, 1) == 1) begin
         stream_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'd1
                                                            : 8'($urandom_range(4, 255)));
      end else begin
         enc = $urandom();
         if (enc == 32'd0) enc = 32'd1;
         add_update_head(16'd2);
         add_rect_head(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)), enc);
      end
      repeat (8) stream_bytes.push_back(8'($urandom()));

      // split the stream at random points, new frame size and gap mode each time
      phase_no = 0;
      while (stream_bytes.size() != 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            write_frame_size(16'($urandom_range(1, 12)), 16'($urandom_range(1, 10)));
         end else if (roll < 70) begin
            if ($urandom_range(0, 1) == 1) write_frame_size(16'd0, 16'($urandom_range(1, 10)));
            else write_frame_size(16'($urandom_range(1, 12)), 16'd0);
         end else if (roll < 80) begin
            write_frame_size(16'hFFFF, 16'($urandom_range(1, 12)));
         end else if (roll < 90) begin
            write_frame_size(16'hFFFF, 16'hFFFF);
         end else begin
            write_frame_size(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
         end
         set_gap_mode(gap_mode_type'(phase_no % 4));
         chunk = $urandom_range(60, 260);
         if (chunk > stream_bytes.size()) chunk = stream_bytes.size();
         feed_and_drain(chunk);
         phase_no++;
      end

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
